>>> src/abp_pkg.sv
`timescale 1ns / 1ps
// package for the american put binomial pricer
// shared widths, lattice size, control structs and fixed point helpers; no dependencies

package abp_pkg;

  localparam int MAX_STEPS = 256;
  localparam int FRAC_BITS = 30;
  localparam int CELLS     = MAX_STEPS + 1;
  localparam int LVL_W     = $clog2(CELLS);
  localparam int PRICE_W   = 32;
  localparam int FACT_W    = 31;
  localparam int PROD_W    = PRICE_W + FACT_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [FACT_W-1:0] FIX_ONE  = FACT_W'(64'd1 << FRAC_BITS);
  localparam logic [63:0]       FIX_HALF = 64'd1 << (FRAC_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS    = 3'd4;

  typedef struct packed {
    logic             seed;
    logic             fwd;
    logic             term;
    logic             mul;
    logic             upd;
    logic [LVL_W-1:0] lvl;
  } cell_ctrl_t;

  typedef struct packed {
    logic [FACT_W-1:0]  prob;
    logic [FACT_W-1:0]  qprob;
    logic [FACT_W-1:0]  disc;
    logic [PRICE_W-1:0] strike;
  } coef_t;

  // (a * f + half) >> frac, saturated to 32 bits
  function automatic logic [PRICE_W-1:0] fix_mul(input logic [PRICE_W-1:0] a,
                                                 input logic [FACT_W-1:0] f);
    logic [63:0] prod;
    prod = 64'(a) * 64'(f) + FIX_HALF;
    prod = prod >> FRAC_BITS;
    if (|prod[63:PRICE_W]) return '1;
    return prod[PRICE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] intrinsic(input logic [PRICE_W-1:0] k,
                                                   input logic [PRICE_W-1:0] s);
    return (k > s) ? (k - s) : '0;
  endfunction

endpackage

>>> src/abp_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module abp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/abp_cell.sv
`timescale 1ns / 1ps
// one lattice column: price register, value register and the price history ram
// depends on abp_pkg and abp_ram

module abp_cell (
  input  logic                            clk,
  input  abp_pkg::cell_ctrl_t             ctrl,
  input  abp_pkg::coef_t                  coef,
  input  logic [abp_pkg::PRICE_W-1:0]     seed_price,
  input  logic [abp_pkg::PRICE_W-1:0]     price_in,
  input  logic [abp_pkg::FACT_W-1:0]      factor,
  input  logic [abp_pkg::PROD_W-1:0]      pv_in,
  output logic [abp_pkg::PRICE_W-1:0]     price_out,
  output logic [abp_pkg::PROD_W-1:0]      pv_out,
  output logic [abp_pkg::PRICE_W-1:0]     value_out
);

  logic [abp_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [abp_pkg::PRICE_W-1:0] value_r, value_nxt;
  logic [abp_pkg::PROD_W-1:0]  pv_r, qv_r;
  logic [abp_pkg::PRICE_W-1:0] hist_price;
  logic [63:0]                 acc;
  logic [abp_pkg::PRICE_W-1:0] expect_v, cont, ex;

  assign price_nxt = ctrl.seed ? seed_price : abp_pkg::fix_mul(price_in, factor);

  abp_ram #(
    .WIDTH(abp_pkg::PRICE_W),
    .DEPTH(abp_pkg::CELLS)
  ) u_hist (
    .clk  (clk),
    .we   (ctrl.fwd),
    .waddr(ctrl.lvl),
    .wdata(price_nxt),
    .raddr(ctrl.lvl),
    .rdata(hist_price)
  );

  always_comb begin
    acc      = 64'(pv_in) + 64'(qv_r) + abp_pkg::FIX_HALF;
    acc      = acc >> abp_pkg::FRAC_BITS;
    expect_v = (|acc[63:abp_pkg::PRICE_W]) ? '1 : acc[abp_pkg::PRICE_W-1:0];
    cont     = abp_pkg::fix_mul(expect_v, coef.disc);
    ex       = abp_pkg::intrinsic(coef.strike, hist_price);
    value_nxt = (cont > ex) ? cont : ex;
  end

  always_ff @(posedge clk) begin
    if (ctrl.fwd) begin
      price_r <= price_nxt;
    end
    if (ctrl.term) begin
      value_r <= abp_pkg::intrinsic(coef.strike, price_r);
    end else if (ctrl.upd) begin
      value_r <= value_nxt;
    end
    if (ctrl.mul) begin
      pv_r <= abp_pkg::PROD_W'(64'(coef.prob) * 64'(value_r));
      qv_r <= abp_pkg::PROD_W'(64'(coef.qprob) * 64'(value_r));
    end
  end

  assign price_out = price_r;
  assign pv_out    = pv_r;
  assign value_out = value_r;

endmodule

>>> src/american_put_binomial_pricer_top.sv
`timescale 1ns / 1ps
// sequence for N lattice steps: forward pass over levels 0..N, terminal payoff state,
// then multiply and update states per backward level, N-1 down to 0, then the output state
// one item in flight: in_stall is high from accept until the output register takes the result
// reset (rst_n low, synchronous): control idles, config registers and out_valid are reset
// depends on abp_pkg and abp_cell

module american_put_binomial_pricer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [abp_pkg::PRICE_W-1:0]       in_spot_price,
  input  logic [abp_pkg::PRICE_W-1:0]       in_strike_price,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [abp_pkg::PRICE_W-1:0]       out_option_price,
  input  logic                              cfg_we,
  input  logic [abp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abp_pkg::FACT_W-1:0]        cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FWD  = 6'b000010,
    S_TERM = 6'b000100,
    S_BA   = 6'b001000,
    S_BB   = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [abp_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [abp_pkg::LVL_W-1:0]   steps_r, steps_nxt;
  logic [abp_pkg::FACT_W-1:0]  up_r, down_r, prob_r, disc_r;
  logic [abp_pkg::LVL_W-1:0]   nsteps_r;
  logic [abp_pkg::PRICE_W-1:0] spot_r, strike_r;
  logic                        out_valid_r;
  logic [abp_pkg::PRICE_W-1:0] out_price_r;
  logic                        in_acc, out_free;
  logic [abp_pkg::FACT_W-1:0]  prob_c;
  abp_pkg::cell_ctrl_t         ctrl;
  abp_pkg::coef_t              coef;

  logic [abp_pkg::PRICE_W-1:0] price_w [abp_pkg::CELLS];
  logic [abp_pkg::PROD_W-1:0]  pv_w    [abp_pkg::CELLS];
  logic [abp_pkg::PRICE_W-1:0] value_w [abp_pkg::CELLS];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // clamp step count into 1..MAX_STEPS
  always_comb begin
    if (nsteps_r == '0) begin
      steps_nxt = abp_pkg::LVL_W'(1);
    end else if (32'(nsteps_r) > abp_pkg::MAX_STEPS) begin
      steps_nxt = abp_pkg::LVL_W'(abp_pkg::MAX_STEPS);
    end else begin
      steps_nxt = nsteps_r;
    end
  end

  assign prob_c = (prob_r > abp_pkg::FIX_ONE) ? abp_pkg::FIX_ONE : prob_r;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_FWD;
          lvl_nxt   = '0;
        end
      end
      S_FWD: begin
        if (lvl_r == steps_r) begin
          state_nxt = S_TERM;
          lvl_nxt   = lvl_r - 1'b1;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      S_TERM: state_nxt = S_BA;
      S_BA:   state_nxt = S_BB;
      S_BB: begin
        if (lvl_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_BA;
          lvl_nxt   = lvl_r - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      up_r        <= abp_pkg::FIX_ONE;
      down_r      <= abp_pkg::FIX_ONE;
      prob_r      <= abp_pkg::FIX_ONE >> 1;
      disc_r      <= abp_pkg::FIX_ONE;
      nsteps_r    <= abp_pkg::LVL_W'(abp_pkg::MAX_STEPS);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          abp_pkg::REG_UP:       up_r     <= cfg_wdata;
          abp_pkg::REG_DOWN:     down_r   <= cfg_wdata;
          abp_pkg::REG_PROB:     prob_r   <= cfg_wdata;
          abp_pkg::REG_DISCOUNT: disc_r   <= cfg_wdata;
          abp_pkg::REG_STEPS:    nsteps_r <= cfg_wdata[abp_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      spot_r   <= in_spot_price;
      strike_r <= in_strike_price;
      steps_r  <= steps_nxt;
    end
    if (state_r == S_FIN && out_free) begin
      out_price_r <= value_w[0];
    end
  end

  assign ctrl.seed = (state_r == S_FWD) && (lvl_r == '0);
  assign ctrl.fwd  = (state_r == S_FWD);
  assign ctrl.term = (state_r == S_TERM);
  assign ctrl.mul  = (state_r == S_BA);
  assign ctrl.upd  = (state_r == S_BB);
  assign ctrl.lvl  = lvl_r;

  assign coef.prob   = prob_c;
  assign coef.qprob  = abp_pkg::FIX_ONE - prob_c;
  assign coef.disc   = disc_r;
  assign coef.strike = strike_r;

  for (genvar j = 0; j < abp_pkg::CELLS; j++) begin : g_cell
    logic [abp_pkg::PRICE_W-1:0] src_price;
    logic [abp_pkg::FACT_W-1:0]  src_factor;
    logic [abp_pkg::PROD_W-1:0]  up_pv;
    // the bottom cell follows its own price down, the others take the lower neighbor up
    if (j == 0) begin : g_base
      assign src_price  = price_w[0];
      assign src_factor = down_r;
    end else begin : g_up
      assign src_price  = price_w[j-1];
      assign src_factor = up_r;
    end
    if (j == abp_pkg::CELLS - 1) begin : g_last
      assign up_pv = '0;
    end else begin : g_mid
      assign up_pv = pv_w[j+1];
    end
    abp_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .coef      (coef),
      .seed_price(spot_r),
      .price_in  (src_price),
      .factor    (src_factor),
      .pv_in     (up_pv),
      .price_out (price_w[j]),
      .pv_out    (pv_w[j]),
      .value_out (value_w[j])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_option_price = out_price_r;

endmodule

>>> src/abp_checker.sv
`timescale 1ns / 1ps
// port level checks for the pricer top, attached by bind
// depends on abp_pkg

module abp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [abp_pkg::PRICE_W-1:0]   out_option_price
);

  // one item in flight: busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_option_price))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind american_put_binomial_pricer_top abp_checker u_abp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_option_price(out_option_price)
);
